// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of the slot allocator.
// No dependencies; included by the file that holds the concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/dsba_pkg.sv -----
// Shared constants and types of the directory-entry slot bitmap allocator.
// No dependencies; used by the top level and by its checker.
package dsba_pkg;

   // Map geometry and field widths.
   localparam int SLOTS  = 52;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int LEN_W  = 9;
   localparam int POS_W  = 6;
   localparam int CNT_W  = 7;
   localparam int STAT_W = 2;

   // Request type codes.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Result status codes.
   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_ROOM  = 2'd1,
      STAT_TOO_LONG = 2'd2
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_DONE
   } state_type;

endpackage

// ----- rtl/dentry_slot_bitmap_allocator_unit.sv -----
// Top level of the directory-entry slot bitmap allocator.
// Depends on dsba_pkg for constants, status codes and sequencer states.
//
// The block holds a 52-slot occupancy map and handles one request at a time.
// An allocate walks the map one slot per cycle from slot 0 and stops at the
// first slot that completes a free run of the needed length; a name that needs
// more than 52 slots is answered straight from acceptance, without a scan. A free
// sweeps all 52 slots. Both walks share the single slot walker.
// req_stall stays high from acceptance until the result has been transferred.
module dentry_slot_bitmap_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [dsba_pkg::LEN_W-1:0]    req_name_len,
   input  logic [dsba_pkg::POS_W-1:0]    req_free_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dsba_pkg::STAT_W-1:0]   rsp_status,
   output logic [dsba_pkg::POS_W-1:0]    rsp_slot_position,
   output logic [dsba_pkg::CNT_W-1:0]    rsp_slot_count
);

   dsba_pkg::state_type               state_ff, state_in;
   logic [dsba_pkg::SLOTS-1:0]        map_ff, map_in;
   logic [dsba_pkg::SLOTS-1:0]        run_mask_ff, run_mask_in;
   logic [dsba_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [dsba_pkg::CNT_W-1:0]        run_len_ff, run_len_in;
   logic [dsba_pkg::POS_W-1:0]        run_start_ff, run_start_in;
   logic [dsba_pkg::CNT_W-1:0]        need_ff, need_in;
   logic [dsba_pkg::CNT_W-1:0]        end_ff, end_in;
   logic [dsba_pkg::POS_W-1:0]        fpos_ff, fpos_in;
   dsba_pkg::status_type              status_ff, status_in;
   logic [dsba_pkg::POS_W-1:0]        pos_ff, pos_in;

   logic [dsba_pkg::LEN_W:0]          len_sum;
   logic [dsba_pkg::CNT_W-1:0]        slots_calc;
   logic [dsba_pkg::SLOTS-1:0]        idx_dec;
   logic [dsba_pkg::CNT_W-1:0]        new_len;
   logic [dsba_pkg::POS_W-1:0]        cur_start;
   logic                              bit_free;
   logic                              last_slot;
   logic                              in_free_run;

   // Slot count of the incoming name: ceil(len / 8).
   assign len_sum    = {1'b0, req_name_len} + (dsba_pkg::LEN_W+1)'(7);
   assign slots_calc = len_sum[dsba_pkg::LEN_W:3];

   // Per-slot terms of the shared walker.
   assign idx_dec   = {{(dsba_pkg::SLOTS-1){1'b0}}, 1'b1} << idx_ff;
   assign bit_free  = !map_ff[idx_ff];
   assign new_len   = run_len_ff + dsba_pkg::CNT_W'(1);
   assign cur_start = (run_len_ff == '0) ? dsba_pkg::POS_W'(idx_ff) : run_start_ff;
   assign last_slot = (idx_ff == dsba_pkg::IDX_W'(dsba_pkg::SLOTS-1));
   assign in_free_run = (dsba_pkg::CNT_W'(idx_ff) >= dsba_pkg::CNT_W'(fpos_ff)) &&
                        (dsba_pkg::CNT_W'(idx_ff) < end_ff);

   // Sequencer and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsba_pkg::S_IDLE;
         map_ff   <= '0;
      end else begin
         state_ff <= state_in;
         map_ff   <= map_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      run_mask_ff  <= run_mask_in;
      idx_ff       <= idx_in;
      run_len_ff   <= run_len_in;
      run_start_ff <= run_start_in;
      need_ff      <= need_in;
      end_ff       <= end_in;
      fpos_ff      <= fpos_in;
      status_ff    <= status_in;
      pos_ff       <= pos_in;
   end

   // Next state, map update and result capture.
   always_comb begin
      state_in     = state_ff;
      map_in       = map_ff;
      run_mask_in  = run_mask_ff;
      idx_in       = idx_ff;
      run_len_in   = run_len_ff;
      run_start_in = run_start_ff;
      need_in      = need_ff;
      end_in       = end_ff;
      fpos_in      = fpos_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;

      case (state_ff)
         dsba_pkg::S_IDLE: begin
            if (req_valid) begin
               need_in      = slots_calc;
               fpos_in      = req_free_position;
               idx_in       = '0;
               run_len_in   = '0;
               run_start_in = '0;
               run_mask_in  = '0;
               end_in       = dsba_pkg::CNT_W'(req_free_position) + slots_calc;
               if (req_type == dsba_pkg::REQ_FREE) begin
                  state_in = dsba_pkg::S_FREE;
               end else if (slots_calc > dsba_pkg::CNT_W'(dsba_pkg::SLOTS)) begin
                  status_in = dsba_pkg::STAT_TOO_LONG;
                  pos_in    = dsba_pkg::POS_W'(dsba_pkg::SLOTS);
                  state_in  = dsba_pkg::S_DONE;
               end else begin
                  state_in = dsba_pkg::S_SCAN;
               end
            end
         end

         dsba_pkg::S_SCAN: begin
            // One slot per cycle: finish on a long enough free run, else extend the current free run or restart it.
            if (bit_free && (new_len >= need_ff)) begin
               if (need_ff != '0) begin
                  map_in = map_ff | run_mask_ff | idx_dec;
               end
               status_in = dsba_pkg::STAT_OK;
               pos_in    = cur_start;
               state_in  = dsba_pkg::S_DONE;
            end else begin
               if (bit_free) begin
                  run_len_in   = new_len;
                  run_start_in = cur_start;
                  run_mask_in  = run_mask_ff | idx_dec;
               end else begin
                  run_len_in  = '0;
                  run_mask_in = '0;
               end
               if (last_slot) begin
                  status_in = dsba_pkg::STAT_NO_ROOM;
                  pos_in    = dsba_pkg::POS_W'(dsba_pkg::SLOTS);
                  state_in  = dsba_pkg::S_DONE;
               end else begin
                  idx_in = idx_ff + dsba_pkg::IDX_W'(1);
               end
            end
         end

         dsba_pkg::S_FREE: begin
            // Clear each slot that falls inside the requested run.
            if (in_free_run) begin
               map_in = map_ff & ~idx_dec;
            end
            if (last_slot) begin
               status_in = dsba_pkg::STAT_OK;
               pos_in    = fpos_ff;
               state_in  = dsba_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + dsba_pkg::IDX_W'(1);
            end
         end

         dsba_pkg::S_DONE: begin
            if (!rsp_stall) begin
               state_in = dsba_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = dsba_pkg::S_IDLE;
         end
      endcase
   end

   // Port drive.
   assign req_stall         = (state_ff != dsba_pkg::S_IDLE);
   assign rsp_valid         = (state_ff == dsba_pkg::S_DONE);
   assign rsp_status        = status_ff;
   assign rsp_slot_position = pos_ff;
   assign rsp_slot_count    = need_ff;

endmodule

// ----- rtl/dsba_checker.sv -----
// Port-level checks of the slot allocator, bound to its top level.
// Depends on dsba_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module dsba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [dsba_pkg::STAT_W-1:0]   rsp_status,
   input logic [dsba_pkg::POS_W-1:0]    rsp_slot_position,
   input logic [dsba_pkg::CNT_W-1:0]    rsp_slot_count
);

   // A stalled result keeps its valid and its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_slot_position) && $stable(rsp_slot_count))

   // The block holds one request at a time: no transfer in while a result waits.
   `ASSERT_IMPLY(a_one_item, clock, reset, rsp_valid, req_stall)

   // A failed allocation reports the out-of-range position.
   `ASSERT_IMPLY(a_no_room_pos, clock, reset, rsp_valid && (rsp_status != dsba_pkg::STAT_OK), rsp_slot_position == dsba_pkg::POS_W'(dsba_pkg::SLOTS))

   // A name reported too long really needs more slots than the map has.
   `ASSERT_IMPLY(a_too_long_cnt, clock, reset, rsp_valid && (rsp_status == dsba_pkg::STAT_TOO_LONG), rsp_slot_count > dsba_pkg::CNT_W'(dsba_pkg::SLOTS))

endmodule

bind dentry_slot_bitmap_allocator_unit dsba_checker u_dsba_checker (.*);

// ----- tb/dentry_slot_bitmap_allocator_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench of the directory-entry slot bitmap allocator. Directed and random allocate
// and free transfers are scored against a slot map that the testbench predicts itself.
// Depends on dsba_pkg and on the dentry_slot_bitmap_allocator_unit RTL.
module dentry_slot_bitmap_allocator_unit_tb;

   localparam int RANDOM_ITEMS = 1430;
   localparam int CALM_TAIL    = 150;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 60;
   localparam int REPORT_LIMIT = 10;
   localparam logic [dsba_pkg::LEN_W-1:0] LEN_MAX = '1;
   localparam logic [dsba_pkg::POS_W-1:0] POS_MAX = '1;

   // One result transfer, as the block presents it.
   typedef struct packed {
      dsba_pkg::status_type            status;
      logic [dsba_pkg::POS_W-1:0]      position;
      logic [dsba_pkg::CNT_W-1:0]      count;
   } slot_result_type;

   // Keeps its own copy of the occupancy map and the results still owed by the block.
   class slot_map_scoreboard;
      logic [dsba_pkg::SLOTS-1:0] occupancy = '0;
      slot_result_type            owed_results[$];
      int                         failures = 0;

      // Applies one accepted request to the map and queues the result it must produce.
      function slot_result_type note_request(logic rtype, logic [dsba_pkg::LEN_W-1:0] len,
                                             logic [dsba_pkg::POS_W-1:0] fpos);
         int              need;
         int              run;
         int              p;
         slot_result_type res;
         need         = (int'(len) + 7) >> 3;
         res.count    = dsba_pkg::CNT_W'(need);
         res.status   = dsba_pkg::STAT_OK;
         res.position = fpos;
         if (rtype == dsba_pkg::REQ_FREE) begin
            // A free run is cut off at the end of the map.
            for (p = int'(fpos); p < int'(fpos) + need; p++)
               if (p < dsba_pkg::SLOTS) occupancy[p] = 1'b0;
         end else if (need > dsba_pkg::SLOTS) begin
            res.status   = dsba_pkg::STAT_TOO_LONG;
            res.position = dsba_pkg::POS_W'(dsba_pkg::SLOTS);
         end else begin
            // First fit: stop at the first free slot that completes a long enough run.
            // A zero length therefore lands on the first free slot.
            res.status   = dsba_pkg::STAT_NO_ROOM;
            res.position = dsba_pkg::POS_W'(dsba_pkg::SLOTS);
            run          = 0;
            for (p = 0; p < dsba_pkg::SLOTS && res.status == dsba_pkg::STAT_NO_ROOM;
                 p++) begin
               run = occupancy[p] ? 0 : run + 1;
               if (run > 0 && run >= need) begin
                  res.status   = dsba_pkg::STAT_OK;
                  res.position = dsba_pkg::POS_W'(p - run + 1);
               end
            end
            if (res.status == dsba_pkg::STAT_OK)
               for (p = int'(res.position); p < int'(res.position) + need; p++)
                  occupancy[p] = 1'b1;
         end
         owed_results.push_back(res);
         return res;
      endfunction

      // Compares one accepted result with the oldest result owed.
      function void check_result(logic [dsba_pkg::STAT_W-1:0] status,
                                 logic [dsba_pkg::POS_W-1:0] position,
                                 logic [dsba_pkg::CNT_W-1:0] count);
         slot_result_type want;
         if (owed_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result: status %0d position %0d count %0d",
                        status, position, count);
            return;
         end
         want = owed_results.pop_front();
         if (status !== want.status || position !== want.position ||
             count !== want.count) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display({"mismatch: expected status %0d position %0d count %0d, ",
                         "got status %0d position %0d count %0d"},
                        want.status, want.position, want.count, status, position, count);
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_type = dsba_pkg::REQ_ALLOC;
   logic [dsba_pkg::LEN_W-1:0]     req_name_len = '0;
   logic [dsba_pkg::POS_W-1:0]     req_free_position = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [dsba_pkg::STAT_W-1:0]    rsp_status;
   logic [dsba_pkg::POS_W-1:0]     rsp_slot_position;
   logic [dsba_pkg::CNT_W-1:0]     rsp_slot_count;

   // While calm is set, neither side idles.
   logic                           calm = 1'b0;
   int                             cycle_count = 0;
   int                             stall_left = 0;
   slot_result_type                live_runs[$];
   slot_map_scoreboard             board = new;

   dentry_slot_bitmap_allocator_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_name_len      (req_name_len),
      .req_free_position (req_free_position),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot_position (rsp_slot_position),
      .rsp_slot_count    (rsp_slot_count)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: score each transfer and stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_status, rsp_slot_position, rsp_slot_count);
      if (reset || calm) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Presents one request, waits for its transfer and records the predicted result.
   // Valid stays high on return so that a back-to-back request does not drop it.
   task automatic send_request(input logic rtype, input logic [dsba_pkg::LEN_W-1:0] len,
                               input logic [dsba_pkg::POS_W-1:0] fpos,
                               output slot_result_type res);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= rtype;
      req_name_len      <= len;
      req_free_position <= fpos;
      do @(posedge clock); while (req_stall);
      res = board.note_request(rtype, len, fpos);
      if (rtype == dsba_pkg::REQ_ALLOC && res.status == dsba_pkg::STAT_OK && res.count != 0)
         live_runs.push_back(res);
   endtask

   // Request side: directed cases, then mostly allocate and free of live runs.
   initial begin
      slot_result_type             res;
      int                          n;
      int                          idx;
      int                          pick;
      logic [dsba_pkg::LEN_W-1:0]  len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Zero length on an empty map, then one-slot and two-slot names.
      send_request(dsba_pkg::REQ_ALLOC, 0, 0, res);
      send_request(dsba_pkg::REQ_ALLOC, 1, 0, res);
      send_request(dsba_pkg::REQ_ALLOC, 8, 0, res);
      send_request(dsba_pkg::REQ_ALLOC, 9, POS_MAX, res);
      // A full-map run that no longer fits, then names that are too long.
      send_request(dsba_pkg::REQ_ALLOC, 416, 0, res);
      send_request(dsba_pkg::REQ_ALLOC, 417, 0, res);
      send_request(dsba_pkg::REQ_ALLOC, LEN_MAX, 0, res);
      send_request(dsba_pkg::REQ_ALLOC, 0, 0, res);
      // Open a one-slot hole that a two-slot name skips and a short name fills.
      send_request(dsba_pkg::REQ_FREE, 8, 1, res);
      send_request(dsba_pkg::REQ_ALLOC, 16, 0, res);
      send_request(dsba_pkg::REQ_ALLOC, 3, 0, res);
      // Clear everything, fill the whole map, then ask on a full map.
      send_request(dsba_pkg::REQ_FREE, LEN_MAX, 0, res);
      send_request(dsba_pkg::REQ_ALLOC, 416, 0, res);
      send_request(dsba_pkg::REQ_ALLOC, 0, 0, res);
      send_request(dsba_pkg::REQ_ALLOC, 1, 0, res);
      send_request(dsba_pkg::REQ_FREE, 8, 51, res);
      send_request(dsba_pkg::REQ_ALLOC, 8, 0, res);
      // A free that starts past the end changes nothing.
      send_request(dsba_pkg::REQ_FREE, LEN_MAX, POS_MAX, res);
      send_request(dsba_pkg::REQ_FREE, 24, 10, res);
      send_request(dsba_pkg::REQ_ALLOC, 32, 0, res);
      send_request(dsba_pkg::REQ_ALLOC, 24, 0, res);
      // A run past the end is cut off; zero length and repeated frees do nothing.
      send_request(dsba_pkg::REQ_FREE, 100, 48, res);
      send_request(dsba_pkg::REQ_FREE, 0, 20, res);
      send_request(dsba_pkg::REQ_FREE, 8, 5, res);
      send_request(dsba_pkg::REQ_FREE, 8, 5, res);
      send_request(dsba_pkg::REQ_FREE, LEN_MAX, 0, res);
      live_runs.delete();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         calm <= (n >= RANDOM_ITEMS - CALM_TAIL) || ((n / 100) % 5 == 2);
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            send_request(dsba_pkg::REQ_FREE, LEN_MAX, 0, res);
            live_runs.delete();
         end else if (pick < 35 && live_runs.size() > 0) begin
            // Release a run handed out earlier, with any length that rounds to its size.
            idx = $urandom_range(0, live_runs.size() - 1);
            len = dsba_pkg::LEN_W'(int'(live_runs[idx].count) * 8 -
                                   int'($urandom_range(0, 7)));
            send_request(dsba_pkg::REQ_FREE, len, live_runs[idx].position, res);
            live_runs.delete(idx);
         end else if (pick < 45) begin
            send_request(dsba_pkg::REQ_FREE, dsba_pkg::LEN_W'($urandom_range(0, 511)),
                         dsba_pkg::POS_W'($urandom_range(0, 63)), res);
         end else if (pick < 55) begin
            send_request(dsba_pkg::REQ_ALLOC, dsba_pkg::LEN_W'($urandom_range(0, 511)),
                         dsba_pkg::POS_W'($urandom), res);
         end else begin
            send_request(dsba_pkg::REQ_ALLOC, dsba_pkg::LEN_W'($urandom_range(0, 64)),
                         dsba_pkg::POS_W'($urandom), res);
         end
      end
      req_valid <= 1'b0;
      calm      <= 1'b1;

      // Drain the outstanding results, then give the block time to show any extra one.
      while (board.owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.owed_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dsba_pkg.sv
rtl/dentry_slot_bitmap_allocator_unit.sv
rtl/dsba_checker.sv
tb/dentry_slot_bitmap_allocator_unit_tb.sv
